// ===== sv/vafc_pkg.sv =====
// Package: widths, pipeline types and the CORDIC arctangent table of the vector angle unit.
package vafc_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int ANGLE_WIDTH = 16;

	// CORDIC depth and fixed-point layout
	localparam int ITER  = 40;
	localparam int GUARD = 24;
	localparam int ZFRAC = 48;
	localparam int QBITS = 60;

	// x/y datapath: sign, coordinate after negation, guard bits, CORDIC growth
	localparam int XY_WIDTH = COORD_WIDTH + GUARD + 4;

	// prep stage + ITER rotation stages + output stage
	localparam int LATENCY = ITER + 2;

	typedef logic signed [XY_WIDTH-1:0] xy_t;
	typedef logic [ZFRAC-1:0]           z_t;
	typedef logic [ANGLE_WIDTH-1:0]     angle_t;

	// Control that travels down the pipeline with each transaction
	typedef struct packed {
		logic valid;
		logic x_zero;
		logic y_neg;
	} ctl_t;

	localparam z_t     HALF_TURN_Z   = z_t'(1) << (ZFRAC - 1);
	localparam z_t     ROUND_HALF_Z  = z_t'(1) << (ZFRAC - ANGLE_WIDTH - 1);
	localparam angle_t QUARTER_TURN  = angle_t'(1) << (ANGLE_WIDTH - 2);
	localparam angle_t HALF_TURN     = angle_t'(1) << (ANGLE_WIDTH - 1);
	localparam angle_t THREE_QUARTER = QUARTER_TURN + HALF_TURN;

	// Elaboration-time helpers for the arctangent table: shift-subtract division.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[63:0], num[k]};
			q = {q[62:0], 1'b0};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(1/n) in Q(QBITS) from its alternating series
	function automatic logic [63:0] atan_recip(input logic [63:0] n);
		logic [63:0] p;
		logic [63:0] s;
		logic [63:0] term;
		p = udiv64(64'd1 << QBITS, n);
		s = '0;
		for (int k = 0; k < 200; k++) begin
			if (p != 64'd0) begin
				term = udiv64(p, 64'(2 * k + 1));
				if ((k & 1) != 0) begin
					s = s - term;
				end else begin
					s = s + term;
				end
				p = udiv64(p, n);
				p = udiv64(p, n);
			end
		end
		return s;
	endfunction

	// round-half-up(a / d * 2^ZFRAC), a < d < 2^63
	function automatic logic [63:0] frac_div(input logic [63:0] a, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = a;
		for (int k = 0; k < ZFRAC; k++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		r = r << 1;
		if (r >= d) begin
			q = q + 64'd1;
		end
		return q;
	endfunction

	// Entry i: atan(2^-i) as a fraction of a turn, ZFRAC bits
	function automatic z_t atan_entry(input int i);
		logic [63:0] qp;
		logic [63:0] tp;
		logic [63:0] q;
		qp = (atan_recip(64'd5) << 2) - atan_recip(64'd239);
		tp = qp << 3;
		if (i == 0) begin
			q = frac_div(qp, tp);
		end else begin
			q = frac_div(atan_recip(64'd1 << i), tp);
		end
		return q[ZFRAC-1:0];
	endfunction

endpackage

// ===== sv/vector_angle_full_circle_unit.sv =====
// Top level: full-circle polar angle of a 2-D vector through a pipelined CORDIC.
//
// Give one vector (vec_x, vec_y) per clock: a transaction is accepted on any rising edge
// with start high and busy low, and busy never rises, so a new vector can enter every
// cycle. The angle appears on angle for one cycle with done high after passing the input
// register, the rotation registers and the output register; the receiver cannot stall
// and results leave in acceptance order. The pipeline has one input stage that folds
// the left half plane onto the right, forty CORDIC micro-rotation stages, and one
// rounding stage. The angle is an unsigned fraction of a turn, 2^ANGLE_WIDTH units per
// full circle, counter-clockwise from the positive x axis. A vector with x equal to zero
// returns a quarter turn for y >= 0 (the zero vector included) and three quarters for
// y < 0; an angle that rounds up to a full turn wraps to zero. No state is kept between
// transactions, and no clearing pass follows reset.
module vector_angle_full_circle_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [vafc_pkg::COORD_WIDTH-1:0] vec_x,
	input  logic signed [vafc_pkg::COORD_WIDTH-1:0] vec_y,
	output logic                                    done,
	output logic        [vafc_pkg::ANGLE_WIDTH-1:0] angle
);
	import vafc_pkg::*;

	// Fully pipelined and never stalled: always ready.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Input fold: negate vectors with x < 0 into the right half plane and preload
	// the angle accumulator with half a turn for them.
	logic                       x_neg;
	logic signed [COORD_WIDTH:0] x_ext;
	logic signed [COORD_WIDTH:0] y_ext;
	xy_t                        x_pre;
	xy_t                        y_pre;
	z_t                         z_pre;

	always_comb begin
		x_neg = vec_x[COORD_WIDTH-1];
		x_ext = {vec_x[COORD_WIDTH-1], vec_x};
		y_ext = {vec_y[COORD_WIDTH-1], vec_y};
		if (x_neg) begin
			x_ext = -x_ext;
			y_ext = -y_ext;
		end
		// scale by 2^GUARD, sign-extended to the datapath width
		x_pre = {{(XY_WIDTH-COORD_WIDTH-1-GUARD){x_ext[COORD_WIDTH]}}, x_ext, {GUARD{1'b0}}};
		y_pre = {{(XY_WIDTH-COORD_WIDTH-1-GUARD){y_ext[COORD_WIDTH]}}, y_ext, {GUARD{1'b0}}};
		z_pre = x_neg ? HALF_TURN_Z : '0;
	end

	ctl_t ctl_s1;
	xy_t  x_s1;
	xy_t  y_s1;
	z_t   z_s1;

	// Capture the control; the x == 0 case bypasses CORDIC via these flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= '{accept, (vec_x == '0), vec_y[COORD_WIDTH-1]};
		end
	end

	// Capture the payload.
	always_ff @(posedge clk) begin
		x_s1 <= x_pre;
		y_s1 <= y_pre;
		z_s1 <= z_pre;
	end

	ctl_t ctl_rot;
	z_t   z_rot;

	vafc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s1),
		.x_in    (x_s1),
		.y_in    (y_s1),
		.z_in    (z_s1),
		.ctl_out (ctl_rot),
		.z_out   (z_rot)
	);

	// Output stage: round the accumulator to ANGLE_WIDTH bits. The add wraps modulo
	// a full turn, so a result that rounds up to 2*pi comes out as zero.
	z_t     z_round;
	angle_t angle_nx;

	always_comb begin
		z_round = z_rot + ROUND_HALF_Z;
		if (ctl_rot.x_zero) begin
			angle_nx = ctl_rot.y_neg ? THREE_QUARTER : QUARTER_TURN;
		end else begin
			angle_nx = z_round[ZFRAC-1 -: ANGLE_WIDTH];
		end
	end

	logic   done_q;
	angle_t angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_rot.valid;
		end
	end

	always_ff @(posedge clk) begin
		angle_q <= angle_nx;
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

// ===== sv/vafc_core.sv =====
// Vectoring CORDIC rotation pipeline, one register stage per micro-rotation.
module vafc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  vafc_pkg::ctl_t    ctl_in,
	input  vafc_pkg::xy_t     x_in,
	input  vafc_pkg::xy_t     y_in,
	input  vafc_pkg::z_t      z_in,
	output vafc_pkg::ctl_t    ctl_out,
	output vafc_pkg::z_t      z_out
);
	import vafc_pkg::*;

	ctl_t ctl_s [ITER+1];
	xy_t  x_s   [ITER];
	xy_t  y_s   [ITER];
	z_t   z_s   [ITER+1];

	assign ctl_s[0] = ctl_in;
	assign x_s[0]   = x_in;
	assign y_s[0]   = y_in;
	assign z_s[0]   = z_in;

	for (genvar i = 0; i < ITER; i++) begin : g_stage
		localparam z_t ATAN_I = atan_entry(i);

		xy_t x_sh;
		xy_t y_sh;
		xy_t x_nx;
		xy_t y_nx;
		z_t  z_nx;

		// Rotate toward the x axis; y sign picks the direction.
		always_comb begin
			x_sh = x_s[i] >>> i;
			y_sh = y_s[i] >>> i;
			if (!y_s[i][XY_WIDTH-1]) begin
				x_nx = x_s[i] + y_sh;
				y_nx = y_s[i] - x_sh;
				z_nx = z_s[i] + ATAN_I;
			end else begin
				x_nx = x_s[i] - y_sh;
				y_nx = y_s[i] + x_sh;
				z_nx = z_s[i] - ATAN_I;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			z_s[i+1] <= z_nx;
		end

		// Drop x/y after the last rotation: only the angle is needed.
		if (i < ITER - 1) begin : g_xy
			always_ff @(posedge clk) begin
				x_s[i+1] <= x_nx;
				y_s[i+1] <= y_nx;
			end
		end
	end

	assign ctl_out = ctl_s[ITER];
	assign z_out   = z_s[ITER];

endmodule

// ===== sv/vafc_checker.sv =====
// Port-level checker for the vector angle unit, bound to the top level.
module vafc_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    start,
	input logic                                    busy,
	input logic signed [vafc_pkg::COORD_WIDTH-1:0] vec_x,
	input logic signed [vafc_pkg::COORD_WIDTH-1:0] vec_y,
	input logic                                    done,
	input logic        [vafc_pkg::ANGLE_WIDTH-1:0] angle
);
	import vafc_pkg::*;

	// Every accepted transaction yields a result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("missing result after accepted transaction");

	// No result without a transaction accepted the fixed latency earlier.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching transaction");

	// x == 0 with y >= 0 (zero vector included) gives a quarter turn.
	a_x_zero_up: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && vec_x == '0 && !vec_y[COORD_WIDTH-1])
		|-> ##LATENCY (angle == QUARTER_TURN))
		else $error("x == 0, y >= 0 did not give a quarter turn");

	// First quadrant stays within a quarter turn.
	a_first_quadrant: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !vec_x[COORD_WIDTH-1] && vec_x != '0 && !vec_y[COORD_WIDTH-1])
		|-> ##LATENCY (angle <= QUARTER_TURN))
		else $error("first-quadrant vector gave an angle beyond a quarter turn");

endmodule

bind vector_angle_full_circle_unit vafc_checker u_vafc_checker (.*);

// ===== tb/sv/vector_angle_full_circle_unit_test.sv =====
// Testbench for the pipelined full-circle vector angle unit, with its own CORDIC angle predictor.
`timescale 1ns / 100ps

module vector_angle_full_circle_unit_test;

	import vafc_pkg::angle_t;

	typedef logic signed [vafc_pkg::COORD_WIDTH-1:0] coord_t;
	typedef longint unsigned                         u64_t;

	// Fixed-point layout of the predictor: rotation count, guard bits on x/y,
	// fraction bits of a turn in the angle sum, and the Q format of the series.
	localparam int SWEEPS      = 40;
	localparam int XY_GUARD    = 24;
	localparam int TURN_FRAC   = 48;
	localparam int SERIES_FRAC = 60;

	localparam angle_t QUARTER_ANGLE = angle_t'(1) << (vafc_pkg::ANGLE_WIDTH - 2);
	localparam angle_t THREE_QUARTER_ANGLE = QUARTER_ANGLE * 3;
	localparam u64_t   TURN_MASK = (u64_t'(1) << TURN_FRAC) - 1;
	localparam u64_t   HALF_TURN_FRAC = u64_t'(1) << (TURN_FRAC - 1);
	localparam u64_t   ROUND_BIT = u64_t'(1) << (TURN_FRAC - vafc_pkg::ANGLE_WIDTH - 1);

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 6;
	localparam int IDLE_PERCENT = 36;
	localparam int RANDOM_COUNT = 1750;
	// Far above the slowest legal run: ~1800 transactions with random gaps plus drain.
	localparam int LIMIT_CYCLES = 200000;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	coord_t vec_x;
	coord_t vec_y;
	logic   done;
	angle_t angle;

	// atan(2^-i) as a fraction of a turn, TURN_FRAC bits, rounded half up
	u64_t   atan_turns [SWEEPS];
	// Angles still owed by the pipeline, oldest first
	angle_t pending_angles [$];

	int     failures;
	int     accepted;
	int     compared;
	int     wrapped;
	int     cycle_count;
	logic   gaps_on;

	vector_angle_full_circle_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.vec_x  (vec_x),
		.vec_y  (vec_y),
		.done   (done),
		.angle  (angle)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Angle predictor
	// ---------------------------------------------------------------

	// atan(1/n) in Q(SERIES_FRAC) from the alternating Taylor series
	function automatic u64_t atan_of_recip(input u64_t n);
		u64_t p;
		u64_t s;
		u64_t term;
		p = (u64_t'(1) << SERIES_FRAC) / n;
		s = 0;
		for (int k = 0; k < 200 && p != 0; k++) begin
			term = p / u64_t'(2 * k + 1);
			if (k % 2 == 1) begin
				s = s - term;
			end else begin
				s = s + term;
			end
			p = p / n;
			p = p / n;
		end
		return s;
	endfunction

	// a/d as a TURN_FRAC-bit fraction, rounded half up; a < d < 2^63
	function automatic u64_t turn_fraction(input u64_t a, input u64_t d);
		u64_t q;
		u64_t r;
		q = 0;
		r = a;
		for (int k = 0; k < TURN_FRAC; k++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 1;
			end
		end
		r = r << 1;
		if (r >= d) begin
			q = q + 1;
		end
		return q;
	endfunction

	// Machin's formula gives pi/4; every entry is then scaled to a fraction of 2*pi.
	function automatic void fill_atan_turns();
		u64_t quarter_pi;
		u64_t two_pi;
		quarter_pi = 4 * atan_of_recip(5) - atan_of_recip(239);
		two_pi = 8 * quarter_pi;
		atan_turns[0] = turn_fraction(quarter_pi, two_pi);
		for (int i = 1; i < SWEEPS; i++) begin
			atan_turns[i] = turn_fraction(atan_of_recip(u64_t'(1) << i), two_pi);
		end
	endfunction

	// Vectoring CORDIC: fold x < 0 onto the right half plane by a half turn,
	// drive y toward zero, accumulate the turned angle, round to the output width.
	function automatic angle_t cordic_angle(input coord_t vx, input coord_t vy);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		u64_t   base;
		u64_t   sum;
		x = vx;
		y = vy;
		z = 0;
		base = 0;
		if (x == 0) begin
			return (y >= 0) ? QUARTER_ANGLE : THREE_QUARTER_ANGLE;
		end
		if (x < 0) begin
			x = -x;
			y = -y;
			base = HALF_TURN_FRAC;
		end
		x = x * (longint'(1) << XY_GUARD);
		y = y * (longint'(1) << XY_GUARD);
		for (int i = 0; i < SWEEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(atan_turns[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(atan_turns[i]);
			end
		end
		sum = (base + u64_t'(z)) & TURN_MASK;
		sum = (sum + ROUND_BIT) >> (TURN_FRAC - vafc_pkg::ANGLE_WIDTH);
		return angle_t'(sum);
	endfunction

	// ---------------------------------------------------------------
	// Scoreboard: results are checked before the same edge's acceptance is
	// queued, which is safe because every angle leaves through pipeline registers.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		angle_t want;
		if (arst_n && done) begin
			if (pending_angles.size() == 0) begin
				$error("angle: no result expected, actual %0d", angle);
				failures++;
			end else begin
				want = pending_angles.pop_front();
				compared++;
				if (angle !== want) begin
					$error("angle: expected %0d, actual %0d", want, angle);
					failures++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			want = cordic_angle(vec_x, vec_y);
			pending_angles.push_back(want);
			accepted++;
			// Count vectors just below the positive x axis that round up to a full turn
			if (want == 0 && vec_y < 0) begin
				wrapped++;
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Offer one vector and hold it until the unit takes it. Before the offer,
	// idle at random with junk on the data ports so gaps land on every stage.
	// Always called right after a rising edge.
	task automatic send_vector(input coord_t x, input coord_t y);
		while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
			start <= 1'b0;
			vec_x <= coord_t'($urandom);
			vec_y <= coord_t'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	// Axes and the zero vector: x equal to zero picks a quarter or three
	// quarters of a turn, with the zero vector on the quarter turn.
	task automatic test_axes();
		send_vector(16'sd0, 16'sd0);
		send_vector(16'sd0, 16'sd1);
		send_vector(16'sd0, 16'sd32767);
		send_vector(16'sd0, -16'sd1);
		send_vector(16'sd0, -16'sd32768);
		send_vector(16'sd1, 16'sd0);
		send_vector(16'sd32767, 16'sd0);
		send_vector(-16'sd1, 16'sd0);
		send_vector(-16'sd32768, 16'sd0);
	endtask

	// Corners of the input range and the diagonals
	task automatic test_corners();
		send_vector(16'sd32767, 16'sd32767);
		send_vector(-16'sd32768, -16'sd32768);
		send_vector(16'sd32767, -16'sd32768);
		send_vector(-16'sd32768, 16'sd32767);
		send_vector(16'sd1, 16'sd1);
		send_vector(-16'sd1, -16'sd1);
		send_vector(-16'sd1, 16'sd1);
		send_vector(16'sd1, -16'sd1);
	endtask

	// Just below the positive x axis the angle can round up to a full turn and
	// must then wrap to zero; just around the negative x axis it sits near a half turn.
	task automatic test_wrap();
		send_vector(16'sd32767, -16'sd1);
		send_vector(16'sd20000, -16'sd1);
		send_vector(16'sd32767, 16'sd1);
		send_vector(-16'sd32768, 16'sd1);
		send_vector(-16'sd32768, -16'sd1);
		send_vector(-16'sd32767, 16'sd32767);
	endtask

	// Random vectors drawn from several shapes; the middle stretch runs
	// back to back with no gaps so the pipeline fills completely.
	task automatic test_random_stream();
		coord_t x;
		coord_t y;
		coord_t edges [6];
		int     shift_x;
		int     shift_y;
		edges = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
		for (int n = 0; n < RANDOM_COUNT; n++) begin
			gaps_on = !(n >= 700 && n < 1000);
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					x = coord_t'($urandom);
					y = coord_t'($urandom);
				end
				4: begin
					x = coord_t'($urandom_range(16) - 8);
					y = coord_t'($urandom_range(16) - 8);
				end
				5: begin
					x = coord_t'($urandom);
					y = coord_t'($urandom);
					case ($urandom_range(3))
						0: x = '0;
						1: y = '0;
						2: x = $urandom_range(1) ? 16'sd1 : -16'sd1;
						default: y = $urandom_range(1) ? 16'sd1 : -16'sd1;
					endcase
				end
				6: begin
					x = coord_t'($urandom_range(32767));
					y = $urandom_range(1) ? x : -x;
					if ($urandom_range(1)) begin
						x = -x;
					end
				end
				7: begin
					x = edges[$urandom_range(5)];
					y = edges[$urandom_range(5)];
				end
				default: begin
					// Spread magnitudes over every scale of the input
					shift_x = $urandom_range(15);
					shift_y = $urandom_range(15);
					x = coord_t'($urandom) >>> shift_x;
					y = coord_t'($urandom) >>> shift_y;
				end
			endcase
			send_vector(x, y);
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		failures = 0;
		accepted = 0;
		compared = 0;
		wrapped = 0;
		cycle_count = 0;
		gaps_on = 1'b1;
		fill_atan_turns();
		arst_n <= 1'b0;
		start <= 1'b0;
		vec_x <= '0;
		vec_y <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_axes();
		test_corners();
		test_wrap();
		test_random_stream();

		// Drop start and drain the pipeline, then watch for stray results
		start <= 1'b0;
		while (pending_angles.size() != 0) begin
			@(posedge clk);
		end
		repeat (vafc_pkg::LATENCY + 10) @(posedge clk);

		$display("Sent %0d vectors (axes, corners, wrap points, random shapes), compared %0d angles",
			accepted, compared);
		$display("Angles wrapped from a full turn to zero: %0d", wrapped);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/vafc_pkg.sv
sv/vafc_core.sv
sv/vector_angle_full_circle_unit.sv
sv/vafc_checker.sv
tb/sv/vector_angle_full_circle_unit_test.sv
